/* rtl/core/i8mm_pkg.sv */
// Shared types and constants for the int8 matrix multiply block.
package i8mm_pkg;

    // Request opcodes
    localparam logic [1:0] OP_WRITE_A = 2'd0;
    localparam logic [1:0] OP_WRITE_B = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_DIM_MISM = 2'd1;
    localparam logic [1:0] STAT_RANGE    = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_A_ROWS = 2'd0;
    localparam logic [1:0] CFG_A_COLS = 2'd1;
    localparam logic [1:0] CFG_B_ROWS = 2'd2;
    localparam logic [1:0] CFG_B_COLS = 2'd3;

    localparam int CNT_W       = 5;
    localparam int IDX_W       = 4;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [IDX_W-1:0]  row_index;
        logic [IDX_W-1:0]  col_index;
        logic signed [7:0] element_value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] product_value;
        logic [1:0]         status;
    } res_t;

    typedef enum logic [1:0] {
        CMD_WR_A,
        CMD_WR_B,
        CMD_QUERY
    } cmd_t;

    // One classified request, as it travels from front to back
    typedef struct packed {
        cmd_t              cmd;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [7:0]        value;
        logic [1:0]        status;
        logic [CNT_W-1:0]  inner_count;
    } entry_t;

endpackage

/* rtl/core/int8_matrix_multiply.sv */
// Top level of the int8 matrix multiply block with 32-bit wrapping accumulation.
//
//  channel   direction  handshake          payload
//  req       in         req_valid/stall    opcode, row, column, element value
//  res       out        res_valid/stall    product value, status
//  cfg       in         cfg_valid/ready    register index, 5-bit count
//
//  Element writes retire at one per cycle through the back end while no query is in progress.
//  An accepted query is processed by the single multiply-accumulate
//  lane, fed by one read port on each store.
//  A refused query, or one with an empty inner dimension, goes straight to the result.
//  The stores are not cleared by reset.
//  A two-entry queue lets requests arrive while the back end stalls on res.
module int8_matrix_multiply #(
    parameter int MAX_DIM = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  i8mm_pkg::req_t              req_data,
    output logic                        res_valid,
    input  logic                        res_stall,
    output i8mm_pkg::res_t              res_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [i8mm_pkg::CNT_W-1:0]  cfg_data
);

    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;
    i8mm_pkg::entry_t push_entry;
    i8mm_pkg::entry_t head;

    assign cfg_ready = 1'b1;

    i8mm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_data   (req_data),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .req_stall  (req_stall),
        .push       (push),
        .push_entry (push_entry)
    );

    i8mm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    i8mm_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

/* rtl/core/i8mm_front.sv */
// Front end: configuration registers and request classification.
module i8mm_front #(
    parameter int MAX_DIM = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  i8mm_pkg::req_t              req_data,
    input  logic                        cfg_valid,
    input  logic [1:0]                  cfg_index,
    input  logic [i8mm_pkg::CNT_W-1:0]  cfg_data,
    input  logic                        q_full,
    output logic                        req_stall,
    output logic                        push,
    output i8mm_pkg::entry_t            push_entry
);

    logic [i8mm_pkg::CNT_W-1:0] a_rows_reg;
    logic [i8mm_pkg::CNT_W-1:0] a_cols_reg;
    logic [i8mm_pkg::CNT_W-1:0] b_rows_reg;
    logic [i8mm_pkg::CNT_W-1:0] b_cols_reg;
    logic [i8mm_pkg::CNT_W-1:0] ar;
    logic [i8mm_pkg::CNT_W-1:0] ac;
    logic [i8mm_pkg::CNT_W-1:0] br;
    logic [i8mm_pkg::CNT_W-1:0] bc;
    logic                       in_store;
    logic                       keep;

    // Saturate a count to the store dimension
    function automatic logic [i8mm_pkg::CNT_W-1:0] clamp_count(
        input logic [i8mm_pkg::CNT_W-1:0] v
    );
        logic [i8mm_pkg::CNT_W-1:0] r;
        r = v;
        if (32'(v) > MAX_DIM)
        begin
            r = i8mm_pkg::CNT_W'(MAX_DIM);
        end
        return r;
    endfunction

    // Configuration registers, written on every valid configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= i8mm_pkg::CNT_W'(16);
            a_cols_reg <= i8mm_pkg::CNT_W'(16);
            b_rows_reg <= i8mm_pkg::CNT_W'(16);
            b_cols_reg <= i8mm_pkg::CNT_W'(16);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                i8mm_pkg::CFG_A_ROWS: a_rows_reg <= cfg_data;
                i8mm_pkg::CFG_A_COLS: a_cols_reg <= cfg_data;
                i8mm_pkg::CFG_B_ROWS: b_rows_reg <= cfg_data;
                i8mm_pkg::CFG_B_COLS: b_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign ar = clamp_count(a_rows_reg);
    assign ac = clamp_count(a_cols_reg);
    assign br = clamp_count(b_rows_reg);
    assign bc = clamp_count(b_cols_reg);

    assign in_store = (32'(req_data.row_index) < MAX_DIM)
                   && (32'(req_data.col_index) < MAX_DIM);

    // Classify the request and work out the query status up front
    always_comb
    begin
        keep                   = 1'b0;
        push_entry.cmd         = i8mm_pkg::CMD_QUERY;
        push_entry.row         = req_data.row_index;
        push_entry.col         = req_data.col_index;
        push_entry.value       = req_data.element_value;
        push_entry.status      = i8mm_pkg::STAT_OK;
        push_entry.inner_count = ac;
        case (req_data.opcode)
            i8mm_pkg::OP_WRITE_A:
            begin
                keep           = in_store;
                push_entry.cmd = i8mm_pkg::CMD_WR_A;
            end
            i8mm_pkg::OP_WRITE_B:
            begin
                keep           = in_store;
                push_entry.cmd = i8mm_pkg::CMD_WR_B;
            end
            i8mm_pkg::OP_QUERY:
            begin
                keep = 1'b1;
                if (ac != br)
                begin
                    push_entry.status = i8mm_pkg::STAT_DIM_MISM;
                end
                else if ((i8mm_pkg::CNT_W'(req_data.row_index) >= ar)
                      || (i8mm_pkg::CNT_W'(req_data.col_index) >= bc))
                begin
                    push_entry.status = i8mm_pkg::STAT_RANGE;
                end
            end
            default: keep = 1'b0;
        endcase
    end

    // Hold requests while the queue is full; drop ignored ones
    assign req_stall = q_full;
    assign push      = req_valid && !q_full && keep;

endmodule

/* rtl/core/i8mm_queue.sv */
// Short queue of classified requests between front and back.
module i8mm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  i8mm_pkg::entry_t  push_entry,
    input  logic              pop,
    output i8mm_pkg::entry_t  head,
    output logic              empty,
    output logic              full
);

    localparam int PTR_W = (i8mm_pkg::QUEUE_DEPTH > 1) ? $clog2(i8mm_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(i8mm_pkg::QUEUE_DEPTH + 1);

    i8mm_pkg::entry_t slot_reg [i8mm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push;
    logic             do_pop;

    assign empty   = (fill_reg == '0);
    assign full    = (fill_reg == CNT_W'(i8mm_pkg::QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == i8mm_pkg::QUEUE_DEPTH - 1)
                            ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == i8mm_pkg::QUEUE_DEPTH - 1)
                            ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/i8mm_back.sv */
// Back end: matrix stores, multiply-accumulate loop and result register.
module i8mm_back #(
    parameter int MAX_DIM = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  i8mm_pkg::entry_t  head,
    input  logic              q_empty,
    output logic              pop,
    output logic              res_valid,
    input  logic              res_stall,
    output i8mm_pkg::res_t    res_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_WAIT = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0] a_mem [DEPTH];
    logic [7:0] b_mem [DEPTH];

    logic [i8mm_pkg::IDX_W-1:0] row_reg;
    logic [i8mm_pkg::IDX_W-1:0] col_reg;
    logic [i8mm_pkg::CNT_W-1:0] count_reg;
    logic [i8mm_pkg::CNT_W-1:0] k_reg;
    logic [1:0]                 status_reg;
    logic [31:0]                acc_reg;
    logic signed [7:0]          a_q_reg;
    logic signed [7:0]          b_q_reg;
    logic                       rd_vld_reg;
    logic                       rd_last_reg;
    logic signed [15:0]         prod_reg;
    logic                       prod_vld_reg;
    logic                       prod_last_reg;
    logic                       res_valid_reg;
    i8mm_pkg::res_t             res_data_reg;

    logic              we_a;
    logic              we_b;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] a_rd_addr;
    logic [ADDR_W-1:0] b_rd_addr;
    logic              issue;
    logic              issue_last;
    logic              slot_free;
    logic              load_res;

    // Take a new entry only between operations
    assign pop        = (state_reg == S_IDLE) && !q_empty;
    assign we_a       = pop && (head.cmd == i8mm_pkg::CMD_WR_A);
    assign we_b       = pop && (head.cmd == i8mm_pkg::CMD_WR_B);
    assign wr_addr    = ADDR_W'(32'(head.row) * MAX_DIM + 32'(head.col));
    assign a_rd_addr  = ADDR_W'(32'(row_reg) * MAX_DIM + 32'(k_reg));
    assign b_rd_addr  = ADDR_W'(32'(k_reg) * MAX_DIM + 32'(col_reg));
    assign issue      = (state_reg == S_RUN);
    assign issue_last = issue && (k_reg == count_reg - 1'b1);
    assign slot_free  = !res_valid_reg || !res_stall;
    assign load_res   = (state_reg == S_DONE) && slot_free;

    // Matrix stores: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            a_mem[wr_addr] <= head.value;
        end
        if (we_b)
        begin
            b_mem[wr_addr] <= head.value;
        end
        a_q_reg <= a_mem[a_rd_addr];
        b_q_reg <= b_mem[b_rd_addr];
    end

    // Sequence the query loop; a refused query or an empty inner dimension goes straight to the result
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pop && (head.cmd == i8mm_pkg::CMD_QUERY))
                begin
                    state_next = ((head.status == i8mm_pkg::STAT_OK)
                                  && (head.inner_count != '0)) ? S_RUN : S_DONE;
                end
            end
            S_RUN:
            begin
                if (issue_last)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (prod_vld_reg && prod_last_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state and pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_vld_reg    <= 1'b0;
            rd_last_reg   <= 1'b0;
            prod_vld_reg  <= 1'b0;
            prod_last_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_vld_reg    <= issue;
            rd_last_reg   <= issue_last;
            prod_vld_reg  <= rd_vld_reg;
            prod_last_reg <= rd_last_reg;
            if (load_res)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Latch the query, step the index, multiply and accumulate
    always_ff @(posedge clk)
    begin
        if (pop && (head.cmd == i8mm_pkg::CMD_QUERY))
        begin
            row_reg    <= head.row;
            col_reg    <= head.col;
            count_reg  <= head.inner_count;
            status_reg <= head.status;
            k_reg      <= '0;
            acc_reg    <= '0;
        end
        else
        begin
            if (issue)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (prod_vld_reg)
            begin
                acc_reg <= acc_reg + {{16{prod_reg[15]}}, prod_reg};
            end
        end
        prod_reg <= a_q_reg * b_q_reg;
        if (load_res)
        begin
            res_data_reg.product_value <= acc_reg;
            res_data_reg.status        <= status_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // The loop index never reaches the bound while reads are issued
    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (k_reg < count_reg))
        else $error("loop index past inner count");

    // The last product lands just before the result is offered
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (prod_vld_reg && prod_last_reg) |=> (state_reg == S_DONE))
        else $error("last product did not finish the query");

    // No new entry is taken while a query is in flight
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_vld_reg || prod_vld_reg) |-> !pop)
        else $error("entry popped during a query");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the int8 matrix multiply block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import i8mm_pkg::*;

    localparam int MAX_DIM       = 16;
    localparam int STORE_DEPTH   = MAX_DIM * MAX_DIM;
    localparam int NUM_PHASES    = 16;
    localparam int PHASE_ITEMS   = 90;
    localparam int SETTLE_CYCLES = 48;
    localparam int TIMEOUT_NS    = 20_000_000;
    localparam int REPORT_LIMIT  = 100;

    // Opcode the block leaves unused
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef logic [3:0][CNT_W-1:0] dims_t;

    typedef struct packed {
        req_t request;
        logic drain_first;
    } pending_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [CNT_W-1:0] cfg_data = '0;

    // Requests waiting to be offered, and products still owed by the block
    pending_t request_queue [$];
    res_t expected_products [$];

    // Mirror of the block: both stores and the register values in force
    logic signed [7:0] a_mirror [STORE_DEPTH];
    logic signed [7:0] b_mirror [STORE_DEPTH];
    dims_t live_dims;

    // Stimulus side: sizes planned for the phase and entries already loaded
    dims_t plan_dims;
    bit a_written [STORE_DEPTH];
    bit b_written [STORE_DEPTH];
    int items_queued = 0;

    int idle_pct = 0;
    int stall_pct = 0;
    int error_count = 0;

    int8_matrix_multiply #(
        .MAX_DIM(MAX_DIM)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_data(req_data),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_data(res_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // Counts above the store size behave as the store size
    function automatic int effective_dim(logic [CNT_W-1:0] count);
        return (count > MAX_DIM) ? MAX_DIM : int'(count);
    endfunction

    // Inner dimensions are compared first, then the indices
    function automatic logic [1:0] query_status(dims_t dims, logic [IDX_W-1:0] row,
                                                logic [IDX_W-1:0] col);
        if (effective_dim(dims[CFG_A_COLS]) != effective_dim(dims[CFG_B_ROWS]))
            return STAT_DIM_MISM;
        if (row >= effective_dim(dims[CFG_A_ROWS]) || col >= effective_dim(dims[CFG_B_COLS]))
            return STAT_RANGE;
        return STAT_OK;
    endfunction

    // Dot product of one row of A with one column of B, wrapping at 32 bits
    function automatic res_t predict_product(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
        res_t product;
        logic signed [31:0] acc;
        product = '0;
        acc = '0;
        product.status = query_status(live_dims, row, col);
        if (product.status == STAT_OK)
        begin
            for (int k = 0; k < effective_dim(live_dims[CFG_A_COLS]); k++)
                acc = acc + a_mirror[row * MAX_DIM + k] * b_mirror[k * MAX_DIM + col];
            product.product_value = acc;
        end
        return product;
    endfunction

    function automatic dims_t make_dims(int a_rows, int a_cols, int b_rows, int b_cols);
        dims_t dims;
        dims[CFG_A_ROWS] = CNT_W'(a_rows);
        dims[CFG_A_COLS] = CNT_W'(a_cols);
        dims[CFG_B_ROWS] = CNT_W'(b_rows);
        dims[CFG_B_COLS] = CNT_W'(b_cols);
        return dims;
    endfunction

    // Mostly small sizes; now and then any 5-bit value, zero and oversize included
    function automatic int random_count();
        if ($urandom_range(9) == 0)
            return $urandom_range(31);
        return $urandom_range(1, $urandom_range(1, MAX_DIM));
    endfunction

    function automatic logic signed [7:0] random_element();
        case ($urandom_range(7))
            0: return 8'sh80;
            1: return 8'sh7F;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < REPORT_LIMIT)
            $display("tb_top: mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic queue_write(logic [1:0] op, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                               logic signed [7:0] value);
        pending_t entry;
        entry.request.opcode = op;
        entry.request.row_index = row;
        entry.request.col_index = col;
        entry.request.element_value = value;
        entry.drain_first = 1'b0;
        request_queue.push_back(entry);
        if (op == OP_WRITE_A)
            a_written[row * MAX_DIM + col] = 1'b1;
        else
            b_written[row * MAX_DIM + col] = 1'b1;
        items_queued++;
    endtask

    // Load any entry the query will read that has never been written, then ask
    task automatic queue_query(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col, bit drain_first);
        pending_t entry;
        if (query_status(plan_dims, row, col) == STAT_OK)
        begin
            for (int k = 0; k < effective_dim(plan_dims[CFG_A_COLS]); k++)
            begin
                if (!a_written[row * MAX_DIM + k])
                    queue_write(OP_WRITE_A, row, IDX_W'(k), random_element());
                if (!b_written[k * MAX_DIM + col])
                    queue_write(OP_WRITE_B, IDX_W'(k), col, random_element());
            end
        end
        entry.request.opcode = OP_QUERY;
        entry.request.row_index = row;
        entry.request.col_index = col;
        entry.request.element_value = 8'($urandom);
        entry.drain_first = drain_first;
        request_queue.push_back(entry);
        items_queued++;
    endtask

    task automatic queue_noise(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                               logic signed [7:0] value);
        pending_t entry;
        entry.request.opcode = OP_UNUSED;
        entry.request.row_index = row;
        entry.request.col_index = col;
        entry.request.element_value = value;
        entry.drain_first = 1'b0;
        request_queue.push_back(entry);
        items_queued++;
    endtask

    // Hold until every request is taken and every product is back, then let it settle
    task automatic wait_quiet();
        while (request_queue.size() != 0 || expected_products.size() != 0 || req_valid)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Called at a rising edge; leaves cfg_valid high for the caller to drop
    task automatic write_register(logic [1:0] index, logic [CNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        live_dims[index] = value;
    endtask

    function automatic dims_t phase_dims(int phase);
        dims_t dims;
        case (phase)
            0: dims = make_dims(2, 2, 2, 2);
            1: dims = make_dims(16, 16, 16, 16);
            2: dims = make_dims(1, 1, 1, 1);
            3: dims = make_dims(4, 7, 5, 9);
            4: dims = make_dims(0, 3, 3, 0);
            5: dims = make_dims(5, 0, 0, 5);
            6: dims = make_dims(31, 20, 17, 31);
            7: dims = make_dims(17, 16, 31, 3);
            default:
            begin
                dims[CFG_A_ROWS] = CNT_W'(random_count());
                dims[CFG_A_COLS] = CNT_W'(random_count());
                dims[CFG_B_COLS] = CNT_W'(random_count());
                if ($urandom_range(4) == 0)
                    dims[CFG_B_ROWS] = CNT_W'(random_count());
                else
                    dims[CFG_B_ROWS] = dims[CFG_A_COLS];
            end
        endcase
        return dims;
    endfunction

    // Drive requests and mirror each one the block takes
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        pending_t head;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                case (req_data.opcode)
                    OP_WRITE_A:
                        a_mirror[req_data.row_index * MAX_DIM + req_data.col_index] =
                            req_data.element_value;
                    OP_WRITE_B:
                        b_mirror[req_data.row_index * MAX_DIM + req_data.col_index] =
                            req_data.element_value;
                    OP_QUERY:
                        expected_products.push_back(
                            predict_product(req_data.row_index, req_data.col_index));
                    default:
                        ;
                endcase
            end
            // offer the next request once the slot is free
            if (!req_valid || !req_stall)
            begin
                if (request_queue.size() != 0 && $urandom_range(99) >= idle_pct &&
                    (!request_queue[0].drain_first ||
                     (expected_products.size() == 0 && !res_valid)))
                begin
                    head = request_queue.pop_front();
                    req_valid <= 1'b1;
                    req_data <= head.request;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Check each product taken against the oldest one owed
    always @(posedge clk or negedge rst_n)
    begin : check_products
        res_t want;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_products.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d status %0d with no query waiting",
                                              res_data.product_value, res_data.status));
                end
                else
                begin
                    want = expected_products.pop_front();
                    if (res_data.product_value !== want.product_value)
                        report_mismatch($sformatf("product_value %0d, expected %0d",
                                                  res_data.product_value, want.product_value));
                    if (res_data.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  res_data.status, want.status));
                end
            end
            res_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Phases: set the sizes while idle, then queue a batch of requests
    initial
    begin : run_phases
        int target;
        int pick;
        int rows;
        int cols;
        bit drain;
        live_dims = make_dims(16, 16, 16, 16);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_quiet();
            plan_dims = phase_dims(phase);
            @(posedge clk);
            write_register(CFG_A_ROWS, plan_dims[CFG_A_ROWS]);
            write_register(CFG_A_COLS, plan_dims[CFG_A_COLS]);
            write_register(CFG_B_ROWS, plan_dims[CFG_B_ROWS]);
            write_register(CFG_B_COLS, plan_dims[CFG_B_COLS]);
            cfg_valid <= 1'b0;
            @(negedge clk);
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 74; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 74; end
                default: begin idle_pct = 8; stall_pct = 8; end
            endcase
            if (phase == 0)
            begin
                // extreme values in a 2x2 product, writes past the sizes, refusals
                queue_write(OP_WRITE_A, 4'd0, 4'd0, 8'sh80);
                queue_write(OP_WRITE_A, 4'd0, 4'd1, 8'sh80);
                queue_write(OP_WRITE_B, 4'd0, 4'd0, 8'sh80);
                queue_write(OP_WRITE_B, 4'd1, 4'd0, 8'sh80);
                queue_write(OP_WRITE_A, 4'd1, 4'd0, 8'sh7F);
                queue_write(OP_WRITE_A, 4'd1, 4'd1, 8'sh7F);
                queue_write(OP_WRITE_B, 4'd0, 4'd1, 8'sh7F);
                queue_write(OP_WRITE_B, 4'd1, 4'd1, 8'sh7F);
                queue_write(OP_WRITE_A, 4'd15, 4'd15, 8'sh55);
                queue_write(OP_WRITE_B, 4'd15, 4'd15, 8'shFF);
                queue_query(4'd0, 4'd0, 1'b1);
                queue_query(4'd0, 4'd1, 1'b0);
                queue_query(4'd1, 4'd0, 1'b0);
                queue_query(4'd1, 4'd1, 1'b0);
                queue_query(4'd2, 4'd0, 1'b0);
                queue_query(4'd0, 4'd2, 1'b0);
                queue_query(4'd15, 4'd15, 1'b0);
                queue_noise(4'd15, 4'd15, 8'shFF);
            end
            else
            begin
                target = items_queued + PHASE_ITEMS;
                rows = effective_dim(plan_dims[CFG_A_ROWS]);
                cols = effective_dim(plan_dims[CFG_B_COLS]);
                while (items_queued < target)
                begin
                    pick = $urandom_range(99);
                    drain = ($urandom_range(59) == 0);
                    if (pick < 45 && rows > 0 && cols > 0)
                        queue_query(IDX_W'($urandom_range(rows - 1)),
                                    IDX_W'($urandom_range(cols - 1)), drain);
                    else if (pick < 60)
                        queue_query(IDX_W'($urandom), IDX_W'($urandom), drain);
                    else if (pick < 90)
                        queue_write((pick < 75) ? OP_WRITE_A : OP_WRITE_B, IDX_W'($urandom),
                                    IDX_W'($urandom), random_element());
                    else
                        queue_noise(IDX_W'($urandom), IDX_W'($urandom), 8'($urandom));
                end
            end
        end
        wait_quiet();
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
